// ===== sv/jstt_pkg.sv =====
// shared types and codes for the job status tracker table
package jstt_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_RD   = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } seq_state_t;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] entry_state_t;

    localparam cmd_t CMD_ADD      = 3'd0;
    localparam cmd_t CMD_FETCH    = 3'd1;
    localparam cmd_t CMD_COMPLETE = 3'd2;
    localparam cmd_t CMD_DELETE   = 3'd3;
    localparam cmd_t CMD_STATUS   = 3'd4;
    localparam cmd_t CMD_RESULT   = 3'd5;

    localparam entry_state_t ES_FREE    = 2'd0;
    localparam entry_state_t ES_PENDING = 2'd1;
    localparam entry_state_t ES_RUNNING = 2'd2;
    localparam entry_state_t ES_DONE    = 2'd3;

    localparam int CAP_BITS      = 5;
    localparam int CAP_RESET     = 10;
    localparam int CFG_ADDR_BITS = 3;
    localparam logic CFG_IDX_CAPACITY = 1'b0;

endpackage

// ===== sv/jstt_store.sv =====
// id and handle memories with one write port and one registered read port
module jstt_store #(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 16,
    parameter int HANDLE_BITS = 32,
    parameter int IW          = $clog2(MAX_ENTRIES)
) (
    input  logic                   aclk,
    input  logic [IW-1:0]          rd_addr,
    output logic [ID_BITS-1:0]     rd_ident,
    output logic [HANDLE_BITS-1:0] rd_ref,
    input  logic [IW-1:0]          wr_addr,
    input  logic                   wr_ident_en,
    input  logic                   wr_ref_en,
    input  logic [ID_BITS-1:0]     wr_ident,
    input  logic [HANDLE_BITS-1:0] wr_ref
);

    logic [ID_BITS-1:0]     ident_mem [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] ref_mem   [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_ident_en) begin
            ident_mem[wr_addr] <= wr_ident;
        end
        if (wr_ref_en) begin
            ref_mem[wr_addr] <= wr_ref;
        end
        rd_ident <= ident_mem[rd_addr];
        rd_ref   <= ref_mem[rd_addr];
    end

endmodule

// ===== sv/job_status_tracker_table_core.sv =====
// job status tracker table top level: sequencer, entry scan and apb register
//
//   channel  direction  beat
//   s_       in         cmd, job_id, job_handle, worker_id
//   m_       out        ok, out_id, out_handle, out_worker, found_status
//   apb      in/out     capacity_limit at byte address 0
//
// an input beat is scanned against every slot, then passes through S_RD, S_FIN and S_OUT to the result beat
// the next input beat can be taken once the result beat has been accepted
// the scan walks the id memory one slot a cycle through one compare
// s_ready is high only when idle and no result is held; m_ready low stalls the result
// aresetn clears all slots to free, the id counter, the pending count and the capacity to 10
module job_status_tracker_table_core #(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_cmd,
    input  logic [ID_BITS-1:0]                    s_job_id,
    input  logic [HANDLE_BITS-1:0]                s_job_handle,
    input  logic [7:0]                            s_worker_id,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_ok,
    output logic [ID_BITS-1:0]                    m_out_id,
    output logic [HANDLE_BITS-1:0]                m_out_handle,
    output logic [7:0]                            m_out_worker,
    output logic [1:0]                            m_found_status,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [jstt_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    jstt_pkg::seq_state_t st_reg, st_next;

    logic [jstt_pkg::CAP_BITS-1:0] cap_reg;
    jstt_pkg::entry_state_t        es_reg   [MAX_ENTRIES];
    logic [IW-1:0]                 rank_reg [MAX_ENTRIES];
    logic [CW-1:0]                 pend_cnt_reg;
    logic [ID_BITS-1:0]            id_ctr_reg;

    jstt_pkg::cmd_t         cmd_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [7:0]             worker_reg;

    logic [CW-1:0] cnt_reg;
    logic          vld_d_reg;
    logic [IW-1:0] idx_d_reg;

    logic [CW-1:0] used_reg;
    logic          free_f_reg, head_f_reg, pm_f_reg, run_f_reg, done_f_reg;
    logic [IW-1:0] free_s_reg, head_s_reg, pm_s_reg, run_s_reg, done_s_reg;
    logic [IW-1:0] pm_rank_reg;

    logic                   ok_reg;
    logic [ID_BITS-1:0]     oid_reg;
    logic [HANDLE_BITS-1:0] oh_reg;
    logic [7:0]             ow_reg;
    logic [1:0]             fs_reg;
    logic                   mv_reg;

    logic [IW-1:0]          rd_addr;
    logic [ID_BITS-1:0]     rd_ident;
    logic [HANDLE_BITS-1:0] rd_ref;
    logic [IW-1:0]          wr_addr;
    logic                   wr_ident_en, wr_ref_en;
    logic [ID_BITS-1:0]     nid;

    logic          accept, issue, hit, add_ok;
    logic [IW-1:0] j;

    assign accept = s_valid && s_ready;
    assign s_ready = (st_reg == jstt_pkg::S_IDLE) && !mv_reg;
    assign issue = (st_reg == jstt_pkg::S_SCAN) && (cnt_reg < CW'(MAX_ENTRIES));
    assign j = idx_d_reg;
    assign hit = (rd_ident == id_reg);
    assign add_ok = (32'(used_reg) < 32'(cap_reg)) && free_f_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == jstt_pkg::CFG_IDX_CAPACITY) ? 32'(cap_reg) : 32'd0;

    assign m_valid        = mv_reg;
    assign m_ok           = ok_reg;
    assign m_out_id       = oid_reg;
    assign m_out_handle   = oh_reg;
    assign m_out_worker   = ow_reg;
    assign m_found_status = fs_reg;

    always_comb begin
        nid = id_ctr_reg + ID_BITS'(1);
        if (nid == '0) begin
            nid = ID_BITS'(1);
        end
    end

    always_comb begin
        if (st_reg == jstt_pkg::S_RD) begin
            rd_addr = (cmd_reg == jstt_pkg::CMD_FETCH) ? head_s_reg : done_s_reg;
        end else begin
            rd_addr = cnt_reg[IW-1:0];
        end
        wr_addr     = free_s_reg;
        wr_ident_en = 1'b0;
        wr_ref_en   = 1'b0;
        if (st_reg == jstt_pkg::S_FIN) begin
            case (cmd_reg)
                jstt_pkg::CMD_ADD: begin
                    wr_ident_en = add_ok;
                    wr_ref_en   = add_ok;
                end
                jstt_pkg::CMD_COMPLETE: begin
                    wr_addr   = run_s_reg;
                    wr_ref_en = run_f_reg;
                end
                default: ;
            endcase
        end
    end

    jstt_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .IW          (IW)
    ) u_store (
        .aclk        (aclk),
        .rd_addr     (rd_addr),
        .rd_ident    (rd_ident),
        .rd_ref      (rd_ref),
        .wr_addr     (wr_addr),
        .wr_ident_en (wr_ident_en),
        .wr_ref_en   (wr_ref_en),
        .wr_ident    (nid),
        .wr_ref      (handle_reg)
    );

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            jstt_pkg::S_IDLE: if (accept) st_next = jstt_pkg::S_SCAN;
            jstt_pkg::S_SCAN: begin
                if (vld_d_reg && (idx_d_reg == IW'(MAX_ENTRIES - 1))) begin
                    st_next = jstt_pkg::S_RD;
                end
            end
            jstt_pkg::S_RD:   st_next = jstt_pkg::S_FIN;
            jstt_pkg::S_FIN:  st_next = jstt_pkg::S_OUT;
            jstt_pkg::S_OUT:  if (m_ready) st_next = jstt_pkg::S_IDLE;
            default:          st_next = jstt_pkg::S_IDLE;
        endcase
    end

    // scan bookkeeping and command latch
    always_ff @(posedge aclk) begin
        vld_d_reg <= issue;
        idx_d_reg <= cnt_reg[IW-1:0];
        if (accept) begin
            cmd_reg    <= s_cmd;
            id_reg     <= s_job_id;
            handle_reg <= s_job_handle;
            worker_reg <= s_worker_id;
            cnt_reg    <= '0;
            used_reg   <= '0;
            free_f_reg <= 1'b0;
            head_f_reg <= 1'b0;
            pm_f_reg   <= 1'b0;
            run_f_reg  <= 1'b0;
            done_f_reg <= 1'b0;
        end else begin
            if (issue) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (st_reg == jstt_pkg::S_SCAN && vld_d_reg) begin
                if (es_reg[j] == jstt_pkg::ES_FREE) begin
                    if (!free_f_reg) begin
                        free_f_reg <= 1'b1;
                        free_s_reg <= j;
                    end
                end else begin
                    used_reg <= used_reg + CW'(1);
                end
                if (es_reg[j] == jstt_pkg::ES_PENDING && rank_reg[j] == '0) begin
                    head_f_reg <= 1'b1;
                    head_s_reg <= j;
                end
                if (es_reg[j] == jstt_pkg::ES_PENDING && hit
                    && (!pm_f_reg || rank_reg[j] < pm_rank_reg)) begin
                    pm_f_reg    <= 1'b1;
                    pm_s_reg    <= j;
                    pm_rank_reg <= rank_reg[j];
                end
                if (es_reg[j] == jstt_pkg::ES_RUNNING && hit && !run_f_reg) begin
                    run_f_reg <= 1'b1;
                    run_s_reg <= j;
                end
                if (es_reg[j] == jstt_pkg::ES_DONE && hit && !done_f_reg) begin
                    done_f_reg <= 1'b1;
                    done_s_reg <= j;
                end
            end
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (st_reg == jstt_pkg::S_FIN) begin
            ok_reg <= 1'b0;
            oid_reg <= '0;
            oh_reg <= '0;
            ow_reg <= '0;
            fs_reg <= 2'd0;
            case (cmd_reg)
                jstt_pkg::CMD_ADD: begin
                    ok_reg  <= add_ok;
                    oid_reg <= add_ok ? nid : '0;
                end
                jstt_pkg::CMD_FETCH: begin
                    if (head_f_reg) begin
                        ok_reg  <= 1'b1;
                        oid_reg <= rd_ident;
                        oh_reg  <= rd_ref;
                        ow_reg  <= worker_reg;
                    end
                end
                jstt_pkg::CMD_COMPLETE: ok_reg <= run_f_reg;
                jstt_pkg::CMD_DELETE:   ok_reg <= pm_f_reg || done_f_reg;
                jstt_pkg::CMD_STATUS: begin
                    ok_reg <= pm_f_reg || run_f_reg || done_f_reg;
                    if (pm_f_reg) begin
                        fs_reg <= 2'd1;
                    end else if (run_f_reg) begin
                        fs_reg <= 2'd2;
                    end else if (done_f_reg) begin
                        fs_reg <= 2'd3;
                    end
                end
                jstt_pkg::CMD_RESULT: begin
                    if (done_f_reg) begin
                        ok_reg <= 1'b1;
                        oh_reg <= rd_ref;
                    end
                end
                default: ;
            endcase
        end
    end

    // control state and table status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= jstt_pkg::S_IDLE;
            cap_reg      <= jstt_pkg::CAP_BITS'(jstt_pkg::CAP_RESET);
            pend_cnt_reg <= '0;
            id_ctr_reg   <= '0;
            mv_reg       <= 1'b0;
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                es_reg[k] <= jstt_pkg::ES_FREE;
            end
        end else begin
            st_reg <= st_next;
            if (psel && penable && pwrite && pready
                && paddr[2] == jstt_pkg::CFG_IDX_CAPACITY) begin
                cap_reg <= pwdata[jstt_pkg::CAP_BITS-1:0];
            end
            if (st_reg == jstt_pkg::S_FIN) begin
                mv_reg <= 1'b1;
                case (cmd_reg)
                    jstt_pkg::CMD_ADD: begin
                        if (add_ok) begin
                            id_ctr_reg           <= nid;
                            es_reg[free_s_reg]   <= jstt_pkg::ES_PENDING;
                            rank_reg[free_s_reg] <= pend_cnt_reg[IW-1:0];
                            pend_cnt_reg         <= pend_cnt_reg + CW'(1);
                        end
                    end
                    jstt_pkg::CMD_FETCH: begin
                        if (head_f_reg) begin
                            es_reg[head_s_reg] <= jstt_pkg::ES_RUNNING;
                            pend_cnt_reg       <= pend_cnt_reg - CW'(1);
                            for (int k = 0; k < MAX_ENTRIES; k++) begin
                                if (es_reg[k] == jstt_pkg::ES_PENDING && rank_reg[k] != '0) begin
                                    rank_reg[k] <= rank_reg[k] - IW'(1);
                                end
                            end
                        end
                    end
                    jstt_pkg::CMD_COMPLETE: begin
                        if (run_f_reg) begin
                            es_reg[run_s_reg] <= jstt_pkg::ES_DONE;
                        end
                    end
                    jstt_pkg::CMD_DELETE: begin
                        if (pm_f_reg) begin
                            es_reg[pm_s_reg] <= jstt_pkg::ES_FREE;
                            pend_cnt_reg     <= pend_cnt_reg - CW'(1);
                            for (int k = 0; k < MAX_ENTRIES; k++) begin
                                if (es_reg[k] == jstt_pkg::ES_PENDING
                                    && rank_reg[k] > pm_rank_reg) begin
                                    rank_reg[k] <= rank_reg[k] - IW'(1);
                                end
                            end
                        end else if (done_f_reg) begin
                            es_reg[done_s_reg] <= jstt_pkg::ES_FREE;
                        end
                    end
                    default: ;
                endcase
            end else if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

endmodule
